// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stuffed frame receiver
// Result word layout, configuration bundle, register indexes and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int MAX_PAYLOAD = 1024;
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam int DRCV_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [15:0] SUM_SEED = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0] ESC_LITERAL = 8'h00;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ETX_BYTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPMAP_W0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPMAP_W1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPMAP_W2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPMAP_W3 = 3'd6;

    localparam logic [7:0] OWN_ADDRESS_RST = 8'd0;
    localparam logic [15:0] TIMEOUT_RST = 16'd200;
    localparam logic [7:0] ETX_BYTE_RST = 8'h03;
    localparam logic [63:0] OPMAP_RST = 64'hFFFF_FFFF_FFFF_FFFF;

    // Input actions.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_BAD_END = 3'd2;
    localparam logic [2:0] ERR_ENCODING = 3'd3;
    localparam logic [2:0] ERR_OPCODE = 3'd4;
    localparam logic [2:0] ERR_CHECKSUM = 3'd5;
    localparam logic [2:0] ERR_TIMEOUT = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW = 3'd7;

    typedef struct packed {
        logic [7:0]   own_address;
        logic [15:0]  timeout_ticks;
        logic [7:0]   etx_byte;
        logic [255:0] opcode_map;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic [7:0]  src_address;
        logic [7:0]  dst_address;
        logic [7:0]  sequence_res;
        logic [7:0]  command;
        logic [15:0] declared_length;
        logic        addressed_to_us;
    } result_t;

endpackage

`default_nettype wire

// ----- design/sfr_parser.sv -----
// ----------------------------------------------------------------------------
// sfr_parser: frame parsing state and per-word result logic
// Updates the frame state for each accepted word and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic            action,
    input  wire logic [7:0]      rx_byte,
    input  wire sfr_pkg::cfg_t   cfg,
    output logic                 res_valid,
    output sfr_pkg::result_t     res
);
    import sfr_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_STX2, PH_MASTER, PH_SLAVE, PH_SEQ, PH_LENLO, PH_LENHI,
        PH_OPCODE, PH_DATA, PH_CRCLO, PH_CRCHI, PH_END1, PH_END2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                esc_reg, esc_next;
    logic [15:0]         run_sum_reg, run_sum_next;
    logic [15:0]         exp_sum_reg, exp_sum_next;
    logic [15:0]         remain_reg, remain_next;
    logic [DRCV_W-1:0]   received_reg, received_next;
    logic [7:0]          src_reg, src_next;
    logic [7:0]          dst_reg, dst_next;
    logic [7:0]          seq_reg, seq_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic [15:0]         length_reg, length_next;
    logic [15:0]         timer_count_reg, timer_count_next;
    logic                timer_run_reg, timer_run_next;

    logic                emit;
    logic [1:0]          emit_kind;
    logic [2:0]          emit_err;
    logic [7:0]          emit_byte;
    logic                take_field;
    logic [7:0]          field_byte;
    logic [15:0]         tick_count;
    logic [15:0]         remain_dec;

    always_comb
    begin
        phase_next = phase_reg;
        esc_next = esc_reg;
        run_sum_next = run_sum_reg;
        exp_sum_next = exp_sum_reg;
        remain_next = remain_reg;
        received_next = received_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        seq_next = seq_reg;
        cmd_next = cmd_reg;
        length_next = length_reg;
        timer_count_next = timer_count_reg;
        timer_run_next = timer_run_reg;
        emit = 1'b0;
        emit_kind = KIND_ERROR;
        emit_err = ERR_NONE;
        emit_byte = 8'd0;
        take_field = 1'b0;
        field_byte = rx_byte;
        tick_count = (timer_count_reg != COUNT_MAX) ? timer_count_reg + 16'd1
                                                    : timer_count_reg;
        remain_dec = (remain_reg != 16'd0) ? remain_reg - 16'd1 : remain_reg;

        if (accept && action == ACT_TICK)
        begin
            if (timer_run_reg)
            begin
                timer_count_next = tick_count;
                if (tick_count >= cfg.timeout_ticks)
                begin
                    emit = 1'b1;
                    emit_err = ERR_TIMEOUT;
                    phase_next = PH_IDLE;
                    esc_next = 1'b0;
                    timer_run_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_STX2:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        phase_next = PH_MASTER;
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_err = ERR_BAD_START;
                        phase_next = PH_IDLE;
                        esc_next = 1'b0;
                        timer_run_next = 1'b0;
                    end
                end
                PH_END1:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        phase_next = PH_END2;
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_err = ERR_BAD_END;
                    end
                end
                PH_END2:
                begin
                    phase_next = PH_IDLE;
                    timer_run_next = 1'b0;
                    emit = 1'b1;
                    if (rx_byte != cfg.etx_byte)
                    begin
                        emit_err = ERR_BAD_END;
                    end
                    else if (exp_sum_reg != run_sum_reg)
                    begin
                        emit_err = ERR_CHECKSUM;
                    end
                    else
                    begin
                        emit_kind = KIND_DONE;
                    end
                end
                PH_MASTER, PH_SLAVE, PH_SEQ, PH_LENLO, PH_LENHI, PH_OPCODE,
                PH_DATA, PH_CRCLO, PH_CRCHI:
                begin
                    // A start byte inside the frame must be followed by the
                    // literal marker; the pair stands for one start byte.
                    if (esc_reg)
                    begin
                        if (rx_byte != ESC_LITERAL)
                        begin
                            emit = 1'b1;
                            emit_err = ERR_ENCODING;
                            phase_next = PH_IDLE;
                            esc_next = 1'b0;
                            timer_run_next = 1'b0;
                        end
                        else
                        begin
                            esc_next = 1'b0;
                            take_field = 1'b1;
                            field_byte = START_BYTE;
                        end
                    end
                    else if (rx_byte == START_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        take_field = 1'b1;
                    end
                end
                default:
                begin
                    if (rx_byte != START_BYTE)
                    begin
                        phase_next = PH_IDLE;
                        emit = 1'b1;
                        emit_err = ERR_BAD_START;
                    end
                    else
                    begin
                        phase_next = PH_STX2;
                        esc_next = 1'b0;
                        timer_count_next = 16'd0;
                        timer_run_next = 1'b1;
                        src_next = 8'd0;
                        dst_next = 8'd0;
                        seq_next = 8'd0;
                        cmd_next = 8'd0;
                        length_next = 16'd0;
                        received_next = '0;
                        remain_next = 16'd0;
                    end
                end
            endcase

            if (take_field)
            begin
                unique case (phase_reg)
                    PH_MASTER:
                    begin
                        src_next = field_byte;
                        run_sum_next = SUM_SEED + {8'd0, field_byte};
                        phase_next = PH_SLAVE;
                    end
                    PH_SLAVE:
                    begin
                        dst_next = field_byte;
                        run_sum_next = run_sum_reg + {8'd0, field_byte};
                        phase_next = PH_SEQ;
                    end
                    PH_SEQ:
                    begin
                        seq_next = field_byte;
                        run_sum_next = run_sum_reg + {8'd0, field_byte};
                        phase_next = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        length_next = {8'd0, field_byte};
                        run_sum_next = run_sum_reg + {8'd0, field_byte};
                        phase_next = PH_LENHI;
                    end
                    PH_LENHI:
                    begin
                        length_next = {field_byte, length_reg[7:0]};
                        run_sum_next = run_sum_reg + {8'd0, field_byte};
                        phase_next = PH_OPCODE;
                    end
                    PH_OPCODE:
                    begin
                        cmd_next = field_byte;
                        if (!cfg.opcode_map[field_byte])
                        begin
                            emit = 1'b1;
                            emit_err = ERR_OPCODE;
                            phase_next = PH_IDLE;
                            esc_next = 1'b0;
                            timer_run_next = 1'b0;
                        end
                        else
                        begin
                            run_sum_next = run_sum_reg + {8'd0, field_byte};
                            received_next = '0;
                            if (length_reg > 16'd1)
                            begin
                                remain_next = length_reg - 16'd1;
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                remain_next = 16'd0;
                                phase_next = PH_CRCLO;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        emit = 1'b1;
                        if (received_reg >= DRCV_W'(MAX_PAYLOAD))
                        begin
                            emit_err = ERR_OVERFLOW;
                            phase_next = PH_IDLE;
                            esc_next = 1'b0;
                            timer_run_next = 1'b0;
                        end
                        else
                        begin
                            received_next = received_reg + DRCV_W'(1);
                            run_sum_next = run_sum_reg + {8'd0, field_byte};
                            remain_next = remain_dec;
                            if (remain_dec == 16'd0)
                            begin
                                phase_next = PH_CRCLO;
                            end
                            emit_kind = KIND_PAYLOAD;
                            emit_byte = field_byte;
                        end
                    end
                    PH_CRCLO:
                    begin
                        exp_sum_next = {8'd0, field_byte};
                        phase_next = PH_CRCHI;
                    end
                    default:
                    begin
                        exp_sum_next = {field_byte, exp_sum_reg[7:0]};
                        phase_next = PH_END1;
                    end
                endcase
            end
        end
    end

    // Every result reports the header fields as they stand after this word.
    always_comb
    begin
        res_valid = emit;
        res.kind = emit_kind;
        res.payload_byte = emit_byte;
        res.error_code = emit_err;
        res.src_address = src_next;
        res.dst_address = dst_next;
        res.sequence_res = seq_next;
        res.command = cmd_next;
        res.declared_length = length_next;
        res.addressed_to_us = (emit_kind != KIND_ERROR) && (dst_next == cfg.own_address);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            esc_reg <= 1'b0;
            run_sum_reg <= 16'd0;
            exp_sum_reg <= 16'd0;
            remain_reg <= 16'd0;
            received_reg <= '0;
            src_reg <= 8'd0;
            dst_reg <= 8'd0;
            seq_reg <= 8'd0;
            cmd_reg <= 8'd0;
            length_reg <= 16'd0;
            timer_count_reg <= 16'd0;
            timer_run_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg <= esc_next;
            run_sum_reg <= run_sum_next;
            exp_sum_reg <= exp_sum_next;
            remain_reg <= remain_next;
            received_reg <= received_next;
            src_reg <= src_next;
            dst_reg <= dst_next;
            seq_reg <= seq_next;
            cmd_reg <= cmd_next;
            length_reg <= length_next;
            timer_count_reg <= timer_count_next;
            timer_run_reg <= timer_run_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sfr_out_buf.sv -----
// ----------------------------------------------------------------------------
// sfr_out_buf: result register with skid stage
// Holds results for the output channel and stalls input only when both
// the output register and the skid stage are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sfr_pkg::result_t  push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output sfr_pkg::result_t       out_data
);
    import sfr_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    result_t   main_reg, main_next;
    result_t   skid_reg, skid_next;
    logic      pop;

    assign pop = main_valid_reg && !out_stall;

    // A push only arrives while the skid stage is empty.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next = main_reg;
        skid_next = skid_reg;
        if (main_valid_reg && !pop)
        begin
            if (push)
            begin
                skid_next = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            main_valid_next = skid_valid_reg || push;
            main_next = skid_valid_reg ? skid_reg : push_data;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_reg;

endmodule

`default_nettype wire

// ----- design/stuffed_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit: byte-stuffed frame receiver
// Parses start/end delimited frames with an additive checksum.
//
// Input channel (in_valid / in_stall): one word per accepted cycle, either
// a received line byte (action 0) or one timer tick (action 1).
// Output channel (out_valid / out_stall): at most one result word per
// input word: a payload byte, a frame-complete report, or an error.
// Configuration channel (cfg_valid / cfg_ready): always ready; the user must
// write it only while the receiver is idle, as the unit does not enforce it.
// Throughput is one input word per cycle while in_stall is low. A result is
// registered in the output register, or in the skid stage if that is held.
// Parsing state is updated in the accepting cycle, so the next word may follow at once.
// When out_stall holds, results collect in the output register and one
// skid stage; in_stall rises only once both are occupied.
// Reset clears the parser to wait for a first start byte, stops the
// timer, empties the output stages and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module stuffed_frame_receiver_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           action,
    input  wire logic [7:0]                     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          kind,
    output logic [7:0]                          payload_byte,
    output logic [2:0]                          error_code,
    output logic [7:0]                          src_address,
    output logic [7:0]                          dst_address,
    output logic [7:0]                          sequence_res,
    output logic [7:0]                          command,
    output logic [15:0]                         declared_length,
    output logic                                addressed_to_us,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                    cfg_data
);
    import sfr_pkg::*;

    cfg_t     cfg_reg;
    logic     accept;
    logic     res_valid;
    result_t  res;
    result_t  out_data;
    logic     buf_full;

    assign cfg_ready = 1'b1;
    assign in_stall = buf_full;
    assign accept = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= OWN_ADDRESS_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.etx_byte <= ETX_BYTE_RST;
            cfg_reg.opcode_map <= {OPMAP_RST, OPMAP_RST, OPMAP_RST, OPMAP_RST};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OWN_ADDRESS: cfg_reg.own_address <= cfg_data[7:0];
                CFG_TIMEOUT:     cfg_reg.timeout_ticks <= cfg_data[15:0];
                CFG_ETX_BYTE:    cfg_reg.etx_byte <= cfg_data[7:0];
                CFG_OPMAP_W0:    cfg_reg.opcode_map[63:0] <= cfg_data;
                CFG_OPMAP_W1:    cfg_reg.opcode_map[127:64] <= cfg_data;
                CFG_OPMAP_W2:    cfg_reg.opcode_map[191:128] <= cfg_data;
                CFG_OPMAP_W3:    cfg_reg.opcode_map[255:192] <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign error_code = out_data.error_code;
    assign src_address = out_data.src_address;
    assign dst_address = out_data.dst_address;
    assign sequence_res = out_data.sequence_res;
    assign command = out_data.command;
    assign declared_length = out_data.declared_length;
    assign addressed_to_us = out_data.addressed_to_us;

endmodule

`default_nettype wire
